/* rtl/mrc_pkg.sv */
// Shared types, constants and word table for the modem result code recogniser.
// Used by every module in rtl/; depends on nothing else.
package mrc_pkg;

  localparam int LINE_MAX_DEF = 29;

  localparam int NUM_WORDS  = 18;
  localparam int WORD_CHARS = 14;

  // Disposition codes
  localparam logic [2:0] DISP_FAIL      = 3'd0;
  localparam logic [2:0] DISP_IGNORE    = 3'd1;
  localparam logic [2:0] DISP_CONNECTED = 3'd2;
  localparam logic [2:0] DISP_RING      = 3'd3;
  localparam logic [2:0] DISP_FAX       = 3'd4;

  // Matched entry codes beyond the word table
  localparam logic [4:0] MATCH_FAX  = 5'd18;
  localparam logic [4:0] MATCH_NONE = 5'd19;

  localparam int CONNECT_ENTRY = 6;
  localparam int FAX_BIT       = 18;
  localparam int ALIVE_W       = 19;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;

  localparam logic [15:0] BAUD_NONE  = 16'd0;
  localparam logic [15:0] BAUD_300   = 16'd300;
  localparam logic [15:0] BAUD_1200  = 16'd1200;
  localparam logic [15:0] BAUD_MAX   = 16'hFFFF;

  typedef logic [8*WORD_CHARS-1:0] word_t;

  // String literals are right-aligned: the last character sits in the low byte
  localparam word_t WORD_TAB [NUM_WORDS] = '{
    "RINGING", "RING RESPONSE", "RING", "+FCON", "FCON", "CONNECT FAX",
    "CONNECT", "V.23 CONNECT", "RRING", "BUSY", "VOICE", "ERROR", "OK",
    "NO CARRIER", "NO DIAL", "DIALING", "NO ANSWER", "DIAL TONE"
  };

  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
    4'd7, 4'd13, 4'd4, 4'd5, 4'd4, 4'd11, 4'd7, 4'd12, 4'd5, 4'd4, 4'd5, 4'd5,
    4'd2, 4'd10, 4'd7, 4'd7, 4'd9, 4'd9
  };

  localparam logic [2:0] WORD_DISP [NUM_WORDS] = '{
    DISP_IGNORE, DISP_IGNORE, DISP_RING, DISP_FAX, DISP_FAX, DISP_FAX,
    DISP_CONNECTED, DISP_CONNECTED, DISP_IGNORE, DISP_FAIL, DISP_FAIL,
    DISP_FAIL, DISP_FAIL, DISP_FAIL, DISP_FAIL, DISP_IGNORE, DISP_FAIL,
    DISP_IGNORE
  };

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
  } mrc_item_t;

  typedef struct packed {
    logic [2:0]  disposition;
    logic [4:0]  matched_entry;
    logic [15:0] baud_rate;
    logic        reliable_info;
  } mrc_result_t;

  // Character p (from the first) of table word idx; zero past the end
  function automatic logic [7:0] word_char(input int idx, input logic [3:0] p);
    int base;
    base = 8 * (int'(WORD_LEN[idx]) - 1 - int'(p));
    if (p < WORD_LEN[idx]) begin
      return WORD_TAB[idx][base +: 8];
    end else begin
      return 8'h00;
    end
  endfunction

  // Fold ASCII a..z to upper case only
  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end else begin
      return c;
    end
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SP) || (c == CHAR_TAB);
  endfunction

endpackage

/* rtl/mrc_in_buf.sv */
// Input skid buffer: a main register and a skid register for incoming items.
// Uses mrc_pkg for the item type; stall is driven straight from a register.
module mrc_in_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrc_pkg::mrc_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output mrc_pkg::mrc_item_t item
);

  logic               main_valid_r, main_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  mrc_pkg::mrc_item_t main_r, main_nxt;
  mrc_pkg::mrc_item_t skid_r, skid_nxt;
  logic               accept;

  assign in_stall   = skid_valid_r;
  assign accept     = in_valid && !skid_valid_r;
  assign item_valid = main_valid_r;
  assign item       = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (take) begin
      // refill main from the skid stage first, then from the port
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        main_nxt = in_item;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!main_valid_r) begin
        main_nxt       = in_item;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = in_item;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

/* rtl/mrc_core.sv */
// Line state and recogniser logic: incremental prefix match, connect-speed
// parse and end-of-line result. Uses mrc_pkg tables, types and functions.
module mrc_core #(
  parameter int LINE_MAX = mrc_pkg::LINE_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  mrc_pkg::mrc_item_t  item,
  input  logic [63:0]         fax_text,
  input  logic [3:0]          fax_length,
  output logic                res_valid,
  output mrc_pkg::mrc_result_t res
);

  localparam int CW = $clog2(LINE_MAX + 1);
  localparam logic [31:0] V23_WORD = "V.23";

  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_BLANKS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [CW-1:0]                count_r, count_nxt;
  logic [mrc_pkg::ALIVE_W-1:0]  alive_r, alive_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [15:0]                  acc_r, acc_nxt;
  logic                         saw_r, saw_nxt;
  logic                         trail_r, trail_nxt;
  logic                         v23_r, v23_nxt;

  always_comb begin
    logic [7:0]                  c, up, fx;
    logic [CW-1:0]               pos, u_count, f_count;
    logic [mrc_pkg::ALIVE_W-1:0] u_alive, f_alive;
    logic [1:0]                  u_phase;
    logic [15:0]                 u_acc, f_acc, baud;
    logic [19:0]                 acc_x10;
    logic                        u_saw, u_trail, u_v23;
    logic                        f_saw, f_trail, f_v23;
    logic                        is_crlf, finish, found, digit;
    logic [3:0]                  fl;
    logic [2:0]                  disp;
    logic [4:0]                  match;
    logic                        rel;

    c   = item.char_code;
    up  = mrc_pkg::fold(c);
    pos = count_r;
    fl  = (fax_length > 4'd8) ? 4'd8 : fax_length;

    // updated state when the item is an ordinary character
    u_alive = alive_r;
    for (int i = 0; i < mrc_pkg::NUM_WORDS; i++) begin
      if (pos < CW'(mrc_pkg::WORD_LEN[i]) && up != mrc_pkg::word_char(i, pos[3:0])) begin
        u_alive[i] = 1'b0;
      end
    end
    fx = fax_text[{pos[2:0], 3'b000} +: 8];
    if (pos < CW'(fl) && up != mrc_pkg::fold(fx)) begin
      u_alive[mrc_pkg::FAX_BIT] = 1'b0;
    end
    u_v23 = v23_r;
    if (pos < CW'(4) && up != V23_WORD[{~pos[1:0], 3'b000} +: 8]) begin
      u_v23 = 1'b0;
    end

    u_phase = phase_r;
    u_acc   = acc_r;
    u_saw   = saw_r;
    u_trail = trail_r;
    digit   = (c >= "0") && (c <= "9");
    acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {16'd0, c[3:0]};
    if (pos >= CW'(7) && alive_r[mrc_pkg::CONNECT_ENTRY] && phase_r != PH_DONE) begin
      if (c == mrc_pkg::CHAR_NUL) begin
        u_phase = PH_DONE;
      end else if (phase_r == PH_PREFIX || phase_r == PH_DIGITS) begin
        if (digit) begin
          u_acc   = (acc_x10 > 20'd65535) ? mrc_pkg::BAUD_MAX : acc_x10[15:0];
          u_saw   = 1'b1;
          u_phase = PH_DIGITS;
        end else if (mrc_pkg::is_blank(c)) begin
          if (phase_r == PH_DIGITS) begin
            u_phase = PH_BLANKS;
          end
        end else begin
          u_trail = 1'b1;
          u_phase = PH_DONE;
        end
      end else if (!mrc_pkg::is_blank(c)) begin
        u_trail = 1'b1;
        u_phase = PH_DONE;
      end
    end
    u_count = pos + CW'(1);

    is_crlf = (c == mrc_pkg::CHAR_CR) || (c == mrc_pkg::CHAR_LF);

    // state that the end-of-line decision looks at
    if (item.cmd || is_crlf) begin
      f_count = count_r;
      f_alive = alive_r;
      f_acc   = acc_r;
      f_saw   = saw_r;
      f_trail = trail_r;
      f_v23   = v23_r;
    end else begin
      f_count = u_count;
      f_alive = u_alive;
      f_acc   = u_acc;
      f_saw   = u_saw;
      f_trail = u_trail;
      f_v23   = u_v23;
    end

    if (item.cmd) begin
      finish = 1'b1;
    end else if (is_crlf) begin
      finish = (count_r != '0);
    end else begin
      finish = (u_count >= CW'(LINE_MAX));
    end

    // first live entry whose whole word has been seen wins
    found = 1'b0;
    match = mrc_pkg::MATCH_NONE;
    disp  = mrc_pkg::DISP_IGNORE;
    for (int i = 0; i < mrc_pkg::NUM_WORDS; i++) begin
      if (!found && f_alive[i] && f_count >= CW'(mrc_pkg::WORD_LEN[i])) begin
        found = 1'b1;
        match = 5'(i);
        disp  = mrc_pkg::WORD_DISP[i];
      end
    end
    if (!found && fl != 4'd0 && f_alive[mrc_pkg::FAX_BIT] && f_count >= CW'(fl)) begin
      match = mrc_pkg::MATCH_FAX;
      disp  = mrc_pkg::DISP_FAX;
    end

    baud = mrc_pkg::BAUD_NONE;
    rel  = 1'b0;
    if (disp == mrc_pkg::DISP_CONNECTED || disp == mrc_pkg::DISP_FAX) begin
      if (f_alive[mrc_pkg::CONNECT_ENTRY] && f_count >= CW'(7)) begin
        rel = f_trail;
        if (!f_saw) begin
          baud = f_trail ? mrc_pkg::BAUD_NONE : mrc_pkg::BAUD_300;
        end else if (f_acc == 16'd1275 || f_acc == 16'd7512 || f_acc == 16'd75 ||
                     f_acc == 16'd212 || f_acc == 16'd12) begin
          baud = mrc_pkg::BAUD_1200;
        end else if (f_acc == 16'd103) begin
          baud = mrc_pkg::BAUD_300;
        end else begin
          baud = f_acc;
        end
      end else if (f_v23 && f_count >= CW'(4)) begin
        baud = mrc_pkg::BAUD_1200;
      end
    end

    res_valid         = advance && finish;
    res.disposition   = disp;
    res.matched_entry = match;
    res.baud_rate     = baud;
    res.reliable_info = rel;

    count_nxt = count_r;
    alive_nxt = alive_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    saw_nxt   = saw_r;
    trail_nxt = trail_r;
    v23_nxt   = v23_r;
    if (advance) begin
      if (finish) begin
        // start a fresh line
        count_nxt = '0;
        alive_nxt = '1;
        phase_nxt = PH_PREFIX;
        acc_nxt   = '0;
        saw_nxt   = 1'b0;
        trail_nxt = 1'b0;
        v23_nxt   = 1'b1;
      end else if (!item.cmd && !is_crlf) begin
        count_nxt = u_count;
        alive_nxt = u_alive;
        phase_nxt = u_phase;
        acc_nxt   = u_acc;
        saw_nxt   = u_saw;
        trail_nxt = u_trail;
        v23_nxt   = u_v23;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      alive_r <= '1;
      phase_r <= PH_PREFIX;
      acc_r   <= '0;
      saw_r   <= 1'b0;
      trail_r <= 1'b0;
      v23_r   <= 1'b1;
    end else begin
      count_r <= count_nxt;
      alive_r <= alive_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      saw_r   <= saw_nxt;
      trail_r <= trail_nxt;
      v23_r   <= v23_nxt;
    end
  end

endmodule

/* rtl/modem_result_code_recognizer.sv */
// Modem result code recogniser: top level with configuration and result register.
// Instantiates mrc_in_buf and mrc_core; uses mrc_pkg types and constants.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per transfer, either a
//   received character (in_cmd = 0, in_char_code) or a flush (in_cmd = 1)
//   that ends the current line. in_stall comes straight from the skid
//   register, so it never depends on out_stall in the same cycle.
//   Result channel (out_valid / out_stall): at most one result per item,
//   raised when a line ends (CR/LF after text, line full, or flush).
//   The item that ends the line passes the input register, then the
//   result register, before its result is presented.
//   Throughput: one item per cycle while the result is not stalled; the line
//   match and the connect-speed accumulation are combinational in mrc_core.
//   A stalled result holds; items keep being accepted until the result
//   register and both input registers are full, then in_stall rises.
//   Reset: all registers empty, an empty line, fax word disabled.
//   Configuration (cfg_we, cfg_index, cfg_wdata): write only while idle.
module modem_result_code_recognizer #(
  parameter int LINE_MAX = mrc_pkg::LINE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_disposition,
  output logic [4:0]  out_matched_entry,
  output logic [15:0] out_baud_rate,
  output logic        out_reliable_info
);

  // Register indexes. RINGING already reports ignore in the table, so a write
  // to the ringing-ignored register changes nothing and is not stored.
  localparam logic [1:0] CFG_FAX_TEXT   = 2'd1;
  localparam logic [1:0] CFG_FAX_LENGTH = 2'd2;

  logic [63:0]          fax_text_r;
  logic [3:0]           fax_length_r;
  mrc_pkg::mrc_item_t   in_item, item;
  logic                 item_valid, take;
  logic                 res_valid;
  mrc_pkg::mrc_result_t res;
  logic                 out_valid_r, out_valid_nxt;
  mrc_pkg::mrc_result_t out_r, out_nxt;

  assign in_item.cmd       = in_cmd;
  assign in_item.char_code = in_char_code;

  // advance the line whenever an item is held and the result register can take a result
  assign take = item_valid && (!out_valid_r || !out_stall);

  mrc_in_buf u_in_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  mrc_core #(
    .LINE_MAX (LINE_MAX)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (take),
    .item       (item),
    .fax_text   (fax_text_r),
    .fax_length (fax_length_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      fax_text_r   <= '0;
      fax_length_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FAX_TEXT:   fax_text_r   <= cfg_wdata;
          CFG_FAX_LENGTH: fax_length_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
    out_r <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_disposition   = out_r.disposition;
  assign out_matched_entry = out_r.matched_entry;
  assign out_baud_rate     = out_r.baud_rate;
  assign out_reliable_info = out_r.reliable_info;

endmodule
